### hw/rtl/cfp_pkg.sv
// Shared types and constants of the command frame parser.
`timescale 1ns / 1ps

package cfp_pkg;

	// Byte codes of the frame format
	localparam logic [7:0] BYTE_SYNC   = 8'hFF;
	localparam logic [7:0] BYTE_HEAD   = 8'hBE;
	localparam logic [7:0] CMD_BUS_A   = 8'h0D;
	localparam logic [7:0] CMD_BUS_B   = 8'h0E;
	localparam logic [7:0] CHECK_MASK  = 8'h7F;
	localparam logic [7:0] SOUND_BASE  = 8'h40;
	localparam logic [7:0] SOUND_LAST  = 8'h59;

	// Most results one frame may replay
	localparam int RESULT_LIMIT = 16;

	// Parse step of the frame
	typedef enum logic [2:0] {
		PS_IDLE  = 3'd0,
		PS_HEAD  = 3'd1,
		PS_CMD   = 3'd2,
		PS_CHECK = 3'd3,
		PS_ADDR  = 3'd4,
		PS_COUNT = 3'd5,
		PS_DATA  = 3'd6
	} parse_t;

	// Sequencer phase: take bytes, or replay stored payload
	typedef enum logic [1:0] {
		PH_ACCEPT = 2'd0,
		PH_READ   = 2'd1,
		PH_LOAD   = 2'd2
	} phase_t;

	// Controller to datapath
	typedef struct packed {
		logic xor_clear;
		logic xor_byte;
		logic hold_cmd;
		logic hold_addr;
		logic hold_count;
		logic data_step;
		logic load_result;
		logic start_replay;
		logic rd_issue;
		logic load_replay;
	} cfp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_sync;
		logic is_head;
		logic byte_is_bus;
		logic data_done;
		logic check_match;
		logic held_is_bus;
		logic replay_zero;
		logic replay_last;
		logic out_free;
	} cfp_stat_t;

endpackage

### hw/rtl/cfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/cfp_datapath.sv
// Datapath of the command frame parser: checksum, held fields, payload store, result register.
`timescale 1ns / 1ps

module cfp_datapath #(
	parameter int PAYLOAD_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  cfp_pkg::cfp_cmd_t  cmd,
	output cfp_pkg::cfp_stat_t stat,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic               frame_status,
	output logic [7:0]         command_code,
	output logic [4:0]         sound_number,
	output logic [7:0]         bus_address,
	output logic [7:0]         byte_count,
	output logic [7:0]         payload_value,
	output logic [7:0]         running_check,
	output logic [7:0]         check_received,
	output logic               last_of_run
);

	import cfp_pkg::*;

	localparam int AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int LIMIT = (PAYLOAD_DEPTH < RESULT_LIMIT) ? PAYLOAD_DEPTH : RESULT_LIMIT;
	localparam int KW    = $clog2(LIMIT + 1);

	logic [7:0]    xor_q;
	logic [7:0]    cmd_q;
	logic [7:0]    addr_q;
	logic [7:0]    count_q;
	logic [7:0]    idx_q;
	logic [7:0]    check_q;
	logic [KW-1:0] k_q;
	logic          valid_q;

	logic [7:0]    idx_next;
	logic          idx_take;
	logic          wr_en;
	logic [KW-1:0] limit;
	logic [7:0]    ram_rdata;
	logic          held_bus;
	logic          held_sound;
	logic [7:0]    sound_diff;

	// Payload index and store gating
	assign idx_take = idx_q < count_q;
	assign idx_next = idx_take ? idx_q + 8'd1 : idx_q;
	assign wr_en    = cmd.data_step && idx_take && (idx_q < 8'(PAYLOAD_DEPTH));

	// Replay length: count capped by store depth and result limit
	assign limit = (count_q < 8'(LIMIT)) ? KW'(count_q) : KW'(LIMIT);

	// Command decode of the held command
	assign held_bus   = (cmd_q == CMD_BUS_A) || (cmd_q == CMD_BUS_B);
	assign held_sound = (cmd_q > SOUND_BASE) && (cmd_q <= SOUND_LAST);
	assign sound_diff = cmd_q - SOUND_BASE;

	// Status to the controller
	always_comb begin
		stat.is_sync     = rx_byte == BYTE_SYNC;
		stat.is_head     = rx_byte == BYTE_HEAD;
		stat.byte_is_bus = (rx_byte == CMD_BUS_A) || (rx_byte == CMD_BUS_B);
		stat.data_done   = idx_next == count_q;
		stat.check_match = rx_byte == (xor_q & CHECK_MASK);
		stat.held_is_bus = held_bus;
		stat.replay_zero = limit == '0;
		stat.replay_last = (k_q + KW'(1)) == limit;
		stat.out_free    = !valid_q || m_tready;
	end

	cfp_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_q[AW-1:0]),
		.wr_data(rx_byte),
		.rd_en  (cmd.rd_issue),
		.rd_addr(AW'(k_q)),
		.rd_data(ram_rdata)
	);

	// Checksum, held fields, payload index, replay counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q   <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.xor_clear) begin
				xor_q <= '0;
			end else if (cmd.xor_byte || (cmd.data_step && idx_take)) begin
				xor_q <= xor_q ^ rx_byte;
			end
			if (cmd.hold_cmd) begin
				cmd_q <= rx_byte;
			end
			if (cmd.hold_addr) begin
				addr_q <= rx_byte;
			end
			if (cmd.hold_count) begin
				count_q <= rx_byte;
				idx_q   <= '0;
			end else if (cmd.data_step) begin
				idx_q <= idx_next;
			end
			if (cmd.start_replay) begin
				k_q <= '0;
			end else if (cmd.load_replay) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	// Check byte kept for the replayed results
	always_ff @(posedge clk) begin
		if (cmd.start_replay) begin
			check_q <= rx_byte;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_replay) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_result || cmd.load_replay) begin
			command_code  <= cmd_q;
			sound_number  <= held_sound ? sound_diff[4:0] : 5'd0;
			bus_address   <= held_bus ? addr_q : 8'd0;
			byte_count    <= held_bus ? count_q : 8'd0;
			running_check <= xor_q;
		end
		if (cmd.load_result) begin
			frame_status   <= !stat.check_match;
			payload_value  <= 8'd0;
			check_received <= rx_byte;
			last_of_run    <= 1'b1;
		end else if (cmd.load_replay) begin
			frame_status   <= 1'b0;
			payload_value  <= ram_rdata;
			check_received <= check_q;
			last_of_run    <= stat.replay_last;
		end
	end

	assign m_tvalid = valid_q;

endmodule

### hw/rtl/cfp_ctrl.sv
// Controller of the command frame parser: parse step and replay sequencer.
`timescale 1ns / 1ps

module cfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cfp_pkg::cfp_stat_t stat,
	output cfp_pkg::cfp_cmd_t  cmd
);

	import cfp_pkg::*;

	parse_t step_q, step_d;
	phase_t phase_q, phase_d;
	logic   fire;

	assign s_tready = (phase_q == PH_ACCEPT) && stat.out_free;
	assign fire     = s_tvalid && s_tready;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= PS_IDLE;
			phase_q <= PH_ACCEPT;
		end else begin
			step_q  <= step_d;
			phase_q <= phase_d;
		end
	end

	// Next state
	always_comb begin
		step_d  = step_q;
		phase_d = phase_q;
		unique case (phase_q)
			PH_ACCEPT: begin
				if (fire) begin
					if (stat.is_sync) begin
						step_d = PS_HEAD;
					end else begin
						unique case (step_q)
							PS_HEAD:  step_d = stat.is_head ? PS_CMD : PS_IDLE;
							PS_CMD:   step_d = stat.byte_is_bus ? PS_ADDR : PS_CHECK;
							PS_ADDR:  step_d = PS_COUNT;
							PS_COUNT: step_d = PS_DATA;
							PS_DATA:  step_d = stat.data_done ? PS_CHECK : PS_DATA;
							PS_CHECK: begin
								step_d = PS_IDLE;
								if (stat.check_match && stat.held_is_bus && !stat.replay_zero) begin
									phase_d = PH_READ;
								end
							end
							default:  step_d = PS_IDLE;
						endcase
					end
				end
			end
			PH_READ: phase_d = PH_LOAD;
			PH_LOAD: begin
				if (stat.out_free) begin
					phase_d = stat.replay_last ? PH_ACCEPT : PH_READ;
				end
			end
			default: phase_d = PH_ACCEPT;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (phase_q)
			PH_ACCEPT: begin
				if (fire) begin
					if (stat.is_sync) begin
						cmd.xor_clear = 1'b1;
					end else begin
						unique case (step_q)
							PS_HEAD: cmd.xor_byte = 1'b1;
							PS_CMD: begin
								cmd.hold_cmd = 1'b1;
								cmd.xor_byte = 1'b1;
							end
							PS_ADDR: cmd.hold_addr = 1'b1;
							PS_COUNT: begin
								cmd.hold_count = 1'b1;
								cmd.xor_clear  = 1'b1;
							end
							PS_DATA: cmd.data_step = 1'b1;
							PS_CHECK: begin
								if (stat.check_match && stat.held_is_bus && !stat.replay_zero) begin
									cmd.start_replay = 1'b1;
								end else begin
									cmd.load_result = 1'b1;
								end
							end
							default: cmd = '0;
						endcase
					end
				end
			end
			PH_READ: cmd.rd_issue = 1'b1;
			PH_LOAD: cmd.load_replay = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/command_frame_parser.sv
// Top level of the command frame parser: stream ports around controller and datapath.
`timescale 1ns / 1ps

// Takes one received byte per accepted request and parses sync 0xFF, header
// 0xBE, command, and for bus commands 0x0D/0x0E an address, a count and the
// payload, ending in a check byte compared with the XOR checksum masked to
// 7 bits. The check byte gives one result, except for an accepted bus
// frame, which replays min(count, PAYLOAD_DEPTH, 16) stored payload bytes,
// each by a registered read of the payload RAM, then a load of the output
// register; input is held off during the replay. An output register parts
// the two sides; a new byte is taken when the output register is empty or
// drains in that cycle. PAYLOAD_DEPTH sets the payload RAM depth (1 to 64).
module command_frame_parser #(
	parameter int PAYLOAD_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] command_code, [12:8] sound_number, [20:13] bus_address,
	// [28:21] byte_count, [36:29] payload_value, [44:37] running_check,
	// [52:45] check_received, [55:53] zero
	output logic [55:0] m_tdata,
	output logic        m_tuser,   // [0] frame_status
	output logic        m_tlast    // last_of_run
);

	import cfp_pkg::*;

	cfp_cmd_t   cmd;
	cfp_stat_t  stat;
	logic [7:0] command_code;
	logic [4:0] sound_number;
	logic [7:0] bus_address;
	logic [7:0] byte_count;
	logic [7:0] payload_value;
	logic [7:0] running_check;
	logic [7:0] check_received;

	cfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	cfp_datapath #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (s_tdata),
		.cmd           (cmd),
		.stat          (stat),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.frame_status  (m_tuser),
		.command_code  (command_code),
		.sound_number  (sound_number),
		.bus_address   (bus_address),
		.byte_count    (byte_count),
		.payload_value (payload_value),
		.running_check (running_check),
		.check_received(check_received),
		.last_of_run   (m_tlast)
	);

	// Pack result fields, lowest first
	assign m_tdata = {3'b000, check_received, running_check, payload_value,
		byte_count, bus_address, sound_number, command_code};

endmodule
